FILE: hdl/cvdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvdr_pkg: shared types and constants for the cv setpoint dac ranger
// Beat payloads, action codes, register indexes and divider handshake.
// ----------------------------------------------------------------------------
package cvdr_pkg;

	// fixed-point shift of the dac code and code width
	localparam int FRAC_SHIFT = 16;
	localparam int CODE_W     = 16;
	localparam int CNT_W      = $clog2(FRAC_SHIFT);

	// register index width and codes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_HYST_UP        = 3'd0;
	localparam logic [IDX_W-1:0] REG_HYST_DOWN      = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_HIGH    = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_LOW     = 3'd3;
	localparam logic [IDX_W-1:0] REG_SLOPE_HIGH     = 3'd4;
	localparam logic [IDX_W-1:0] REG_SLOPE_LOW      = 3'd5;
	localparam logic [IDX_W-1:0] REG_DAC_LIMIT      = 3'd6;
	localparam logic [IDX_W-1:0] REG_SETPOINT_LIMIT = 3'd7;

	// item actions
	typedef enum logic [1:0] {
		ACT_SET  = 2'd0,
		ACT_UP   = 2'd1,
		ACT_DOWN = 2'd2,
		ACT_APPLY = 2'd3
	} action_t;

	// input beat
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] amount;
		logic        autorange_ok;
		logic        mode_was_cv;
	} in_t;

	// result beat
	typedef struct packed {
		logic [31:0]       setpoint;
		logic [CODE_W-1:0] dac_code;
		logic              dac_valid;
		logic              high_range;
		logic              invalidate;
		logic              overload;
		logic [15:0]       error_count;
	} out_t;

	// divider request: positive offset sum and range slope
	typedef struct packed {
		logic        start;
		logic [32:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	// divider response: quotient valid for one cycle
	typedef struct packed {
		logic              done;
		logic              sat;
		logic [CODE_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: hdl/cvdr_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvdr_frac_div: serial fractional divider
// Computes (dividend << 16) / divisor one quotient bit a cycle through one
// shared subtractor; flags saturation when the quotient needs more than
// sixteen bits (dividend not below divisor, which covers a zero divisor).
// ----------------------------------------------------------------------------
module cvdr_frac_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cvdr_pkg::div_req_t req,
	output cvdr_pkg::div_rsp_t rsp
);

	typedef enum logic [2:0] {
		DV_IDLE  = 3'b001,
		DV_CHECK = 3'b010,
		DV_STEP  = 3'b100
	} dv_state_t;

	dv_state_t                        state_q;
	logic [32:0]                      num_q;
	logic [31:0]                      den_q;
	logic [cvdr_pkg::CODE_W-1:0]      quot_q;
	logic [cvdr_pkg::CNT_W-1:0]       cnt_q;
	logic                             done_q;
	logic                             sat_q;

	logic [32:0] alu_a;
	logic [33:0] diff;
	logic        no_borrow;

	// shared subtractor: range check first, then shifted remainder
	assign alu_a     = (state_q == DV_CHECK) ? num_q : {num_q[31:0], 1'b0};
	assign diff      = {1'b0, alu_a} - {2'b00, den_q};
	assign no_borrow = ~diff[33];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (req.start) begin
						state_q <= DV_CHECK;
						sat_q   <= 1'b0;
					end
				end
				DV_CHECK: begin
					cnt_q <= '0;
					if (no_borrow) begin
						sat_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						state_q <= DV_STEP;
					end
				end
				DV_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == cvdr_pkg::CNT_W'(cvdr_pkg::FRAC_SHIFT - 1)) begin
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// remainder and quotient datapath
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (req.start) begin
					num_q <= req.dividend;
					den_q <= req.divisor;
				end
			end
			DV_CHECK: begin
				quot_q <= '0;
			end
			DV_STEP: begin
				quot_q <= {quot_q[cvdr_pkg::CODE_W-2:0], no_borrow};
				num_q  <= no_borrow ? {1'b0, diff[31:0]} : {1'b0, alu_a[31:0]};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.quot = quot_q;

endmodule

FILE: hdl/cv_setpoint_dac_ranger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv_setpoint_dac_ranger_unit: constant-voltage setpoint and dac ranger
// Holds the setpoint, picks the range with hysteresis and produces the
// saturated dac code for apply beats.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register. Set, step-up and step-down
// items pass from S_PREP straight to S_DONE, and so does an apply item whose
// offset sum is zero or negative. One whose offset sum is not below the
// slope, so that the quotient needs more than 16 bits or the slope is zero,
// waits in S_WAIT for the divider's range check only. Any other apply item
// waits in S_WAIT for the full division, whether or not the code is then
// clamped to the dac limit: the divider resolves one quotient bit a cycle
// through a single shared 33-bit subtractor for the 16 fraction bits. A
// waiting result holds off completion of the next item, not its acceptance.
// No clearing pass after reset. Configuration is written through wr_en,
// wr_index and wr_data while the block is idle; the user is bound to that,
// and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cv_setpoint_dac_ranger_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cvdr_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output cvdr_pkg::out_t                     out_data,
	input  logic                               wr_en,
	input  logic [cvdr_pkg::IDX_W-1:0]         wr_index,
	input  logic [31:0]                        wr_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_WAIT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [31:0]                 hyst_up_q;
	logic [31:0]                 hyst_down_q;
	logic [31:0]                 offset_high_q;
	logic [31:0]                 offset_low_q;
	logic [31:0]                 slope_high_q;
	logic [31:0]                 slope_low_q;
	logic [cvdr_pkg::CODE_W-1:0] dac_limit_q;
	logic [31:0]                 setpoint_limit_q;

	// block state
	logic [31:0] setpoint_q;
	logic        range_q;
	logic [15:0] err_q;

	// item working registers
	cvdr_pkg::in_t               item_q;
	logic [31:0]                 new_sp_q;
	logic                        rng_q;
	logic [cvdr_pkg::CODE_W-1:0] code_q;
	logic                        ovl_q;

	// output register
	cvdr_pkg::out_t out_q;
	logic           out_valid_q;

	cvdr_pkg::div_req_t div_req;
	cvdr_pkg::div_rsp_t div_rsp;

	logic        is_apply;
	logic [32:0] up_sum;
	logic [31:0] up_sp;
	logic [31:0] down_sp;
	logic        rng_sel;
	logic [31:0] off_sel;
	logic [33:0] off_sum;
	logic        sum_pos;
	logic        load_out;
	logic        div_sat;

	assign is_apply = (item_q.action == cvdr_pkg::ACT_APPLY);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_up_q        <= '0;
			hyst_down_q      <= '0;
			offset_high_q    <= '0;
			offset_low_q     <= '0;
			slope_high_q     <= 32'h0001_0000;
			slope_low_q      <= 32'h0001_0000;
			dac_limit_q      <= '1;
			setpoint_limit_q <= '1;
		end else if (wr_en) begin
			case (wr_index)
				cvdr_pkg::REG_HYST_UP:        hyst_up_q        <= wr_data;
				cvdr_pkg::REG_HYST_DOWN:      hyst_down_q      <= wr_data;
				cvdr_pkg::REG_OFFSET_HIGH:    offset_high_q    <= wr_data;
				cvdr_pkg::REG_OFFSET_LOW:     offset_low_q     <= wr_data;
				cvdr_pkg::REG_SLOPE_HIGH:     slope_high_q     <= wr_data;
				cvdr_pkg::REG_SLOPE_LOW:      slope_low_q      <= wr_data;
				cvdr_pkg::REG_DAC_LIMIT:      dac_limit_q      <= wr_data[cvdr_pkg::CODE_W-1:0];
				cvdr_pkg::REG_SETPOINT_LIMIT: setpoint_limit_q <= wr_data;
				default: ;
			endcase
		end
	end

	// step arithmetic, clamped high and low
	assign up_sum  = {1'b0, setpoint_q} + {1'b0, item_q.amount};
	assign up_sp   = (up_sum[32] || (up_sum[31:0] >= setpoint_limit_q))
		? (setpoint_limit_q - 32'd1) : up_sum[31:0];
	assign down_sp = (item_q.amount > setpoint_q) ? 32'd0 : (setpoint_q - item_q.amount);

	// range choice with hysteresis, forced high without autoranging
	always_comb begin
		if ((setpoint_q > hyst_up_q) || !item_q.autorange_ok)
			rng_sel = 1'b1;
		else if (setpoint_q < hyst_down_q)
			rng_sel = 1'b0;
		else
			rng_sel = range_q;
	end

	// signed offset sum, exact in 34 bits
	assign off_sel = rng_sel ? offset_high_q : offset_low_q;
	assign off_sum = {2'b00, setpoint_q} + {{2{off_sel[31]}}, off_sel};
	assign sum_pos = ~off_sum[33] && (off_sum != '0);

	// divider start on a positive apply sum
	assign div_req.start    = (state_q == S_PREP) && is_apply && sum_pos;
	assign div_req.dividend = off_sum[32:0];
	assign div_req.divisor  = rng_sel ? slope_high_q : slope_low_q;

	cvdr_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_sat  = div_rsp.sat || (div_rsp.quot > dac_limit_q);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= (is_apply && sum_pos) ? S_WAIT : S_DONE;
				end
				S_WAIT: begin
					if (div_rsp.done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			item_q <= in_data;
		if (state_q == S_PREP) begin
			code_q <= '0;
			ovl_q  <= 1'b0;
			case (item_q.action)
				cvdr_pkg::ACT_SET:  new_sp_q <= item_q.amount;
				cvdr_pkg::ACT_UP:   new_sp_q <= up_sp;
				cvdr_pkg::ACT_DOWN: new_sp_q <= down_sp;
				default:            new_sp_q <= setpoint_q;
			endcase
			rng_q <= is_apply ? rng_sel : range_q;
		end
		if (state_q == S_WAIT && div_rsp.done) begin
			code_q <= div_sat ? dac_limit_q : div_rsp.quot;
			ovl_q  <= div_sat && rng_q;
		end
	end

	// block state update at completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			range_q    <= 1'b1;
			err_q      <= '0;
		end else if (load_out) begin
			setpoint_q <= new_sp_q;
			range_q    <= rng_q;
			if (ovl_q) err_q <= err_q + 16'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.setpoint    <= new_sp_q;
			out_q.dac_code    <= code_q;
			out_q.dac_valid   <= is_apply;
			out_q.high_range  <= rng_q;
			out_q.invalidate  <= is_apply && ((rng_q != range_q) || !item_q.mode_was_cv);
			out_q.overload    <= ovl_q;
			out_q.error_count <= ovl_q ? (err_q + 16'd1) : err_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// divider only answers while the sequencer waits for it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAIT))
		else $error("divider response outside wait state");

	// a new result beat only follows the completion state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result beat without completion");

	// error count moves only on a completed overload
	a_err_on_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(err_q) |-> $past(load_out && ovl_q && rng_q))
		else $error("error count changed without overload");

	// overload is only ever raised in the high range
	a_ovl_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.overload) |-> (out_q.high_range && out_q.dac_valid))
		else $error("overload outside high-range apply");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: cv setpoint dac ranger self-checking bench
// Walks a directed table (reset state, clamps, range hysteresis, offset and
// slope corner cases), then random calibration phases with random beats.
// Each result beat is checked field by field against a typed-in result or
// the in-bench predictor, random idling on both sides, one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import cvdr_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 231;
	localparam int IDLE_PCT    = 18;

	// one row of the directed table: a register write or an item beat
	typedef struct {
		bit               is_cfg;
		logic [IDX_W-1:0] idx;
		logic [31:0]      wdata;
		in_t              item;
		bit               typed;
		out_t             golden;
	} plan_row_t;

	// typed-in result travelling with an offered beat
	typedef struct {
		bit   typed;
		out_t golden;
	} typed_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_data;
	logic             wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [31:0]      wr_data = '0;

	// predictor copy of calibration and state
	logic [31:0] reg_shadow [8];
	logic [31:0] sp_model;
	logic        range_model;
	logic [15:0] err_model;

	out_t      pending_results [$];
	typed_t    typed_results [$];
	plan_row_t plan [$];

	int n_sent, n_seen, n_apply, n_low, n_ovl, fail_count, quiet;
	int hold_epoch, hold_seen, hold_left;
	bit calm;

	cv_setpoint_dac_ranger_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always #10 clk = ~clk;

	// expected result of one item beat, advancing the predictor state
	function automatic out_t predict_cv(input in_t it);
		out_t               r;
		logic [31:0]        bumped, off, slope;
		logic signed [63:0] total;
		logic [63:0]        num, quot;
		logic [15:0]        code, dac_lim;
		logic               prev, rng, sat;
		r = '0;
		dac_lim = reg_shadow[REG_DAC_LIMIT][15:0];
		case (action_t'(it.action))
		ACT_SET: sp_model = it.amount;
		ACT_UP: begin
			bumped = sp_model + it.amount;
			if (bumped < sp_model || bumped >= reg_shadow[REG_SETPOINT_LIMIT])
				sp_model = reg_shadow[REG_SETPOINT_LIMIT] - 32'd1;
			else
				sp_model = bumped;
		end
		ACT_DOWN: sp_model = (it.amount > sp_model) ? 32'd0 : sp_model - it.amount;
		default: begin
			prev = range_model;
			if (sp_model > reg_shadow[REG_HYST_UP] || !it.autorange_ok)
				rng = 1'b1;
			else if (sp_model < reg_shadow[REG_HYST_DOWN])
				rng = 1'b0;
			else
				rng = prev;
			off   = rng ? reg_shadow[REG_OFFSET_HIGH] : reg_shadow[REG_OFFSET_LOW];
			slope = rng ? reg_shadow[REG_SLOPE_HIGH] : reg_shadow[REG_SLOPE_LOW];
			total = $signed({32'd0, sp_model}) + $signed({{32{off[31]}}, off});
			sat  = 1'b0;
			code = '0;
			if (total <= 0) begin
				code = '0;
			end else if (slope == 32'd0) begin
				sat  = 1'b1;
				code = dac_lim;
			end else begin
				num  = total;
				quot = (num << FRAC_SHIFT) / {32'd0, slope};
				if (quot > {48'd0, dac_lim}) begin
					sat  = 1'b1;
					code = dac_lim;
				end else begin
					code = quot[15:0];
				end
			end
			// only a high-range saturation is an overload
			if (rng && sat) begin
				r.overload = 1'b1;
				err_model  = err_model + 16'd1;
			end
			range_model  = rng;
			r.dac_code   = code;
			r.dac_valid  = 1'b1;
			r.invalidate = (rng != prev) || !it.mode_was_cv;
		end
		endcase
		r.setpoint    = sp_model;
		r.high_range  = range_model;
		r.error_count = err_model;
		return r;
	endfunction

	function automatic plan_row_t item_row(input action_t act, input logic [31:0] amt,
			input logic autorange, input logic was_cv);
		plan_row_t row;
		row = '{default: '0};
		row.item.action       = act;
		row.item.amount       = amt;
		row.item.autorange_ok = autorange;
		row.item.mode_was_cv  = was_cv;
		return row;
	endfunction

	function automatic plan_row_t gold_row(input action_t act, input logic [31:0] amt,
			input logic autorange, input logic was_cv, input out_t g);
		plan_row_t row;
		row = item_row(act, amt, autorange, was_cv);
		row.typed  = 1'b1;
		row.golden = g;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.wdata  = val;
		return row;
	endfunction

	// offer one beat, idling at random first, and wait until it is taken
	task automatic offer(input in_t item, input bit typed, input out_t golden);
		typed_t t;
		t.typed  = typed;
		t.golden = golden;
		typed_results.push_back(t);
		while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	// let every outstanding result come back so the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (n_seen != n_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		reg_shadow[idx] = val;
		@(posedge clk);
	endtask

	// input acceptance, result checking and watchdog
	always @(posedge clk) begin
		typed_t t;
		out_t   want;
		bit     took_in, took_out;
		took_in  = in_valid && !in_stall;
		took_out = out_valid && !out_stall;
		if (took_out) begin
			n_seen++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: %h", out_data);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					fail_count++;
					if (out_data.setpoint !== want.setpoint)
						$error("setpoint: expected %h, got %h", want.setpoint, out_data.setpoint);
					if (out_data.dac_code !== want.dac_code)
						$error("dac_code: expected %h, got %h", want.dac_code, out_data.dac_code);
					if (out_data.dac_valid !== want.dac_valid)
						$error("dac_valid: expected %b, got %b", want.dac_valid,
							out_data.dac_valid);
					if (out_data.high_range !== want.high_range)
						$error("high_range: expected %b, got %b", want.high_range,
							out_data.high_range);
					if (out_data.invalidate !== want.invalidate)
						$error("invalidate: expected %b, got %b", want.invalidate,
							out_data.invalidate);
					if (out_data.overload !== want.overload)
						$error("overload: expected %b, got %b", want.overload, out_data.overload);
					if (out_data.error_count !== want.error_count)
						$error("error_count: expected %h, got %h", want.error_count,
							out_data.error_count);
				end
			end
		end
		if (took_in) begin
			t    = typed_results.pop_front();
			want = predict_cv(in_data);
			if (action_t'(in_data.action) == ACT_APPLY) begin
				n_apply++;
				if (!want.high_range)
					n_low++;
				if (want.overload)
					n_ovl++;
			end
			pending_results.push_back(t.typed ? t.golden : want);
		end
		// nothing moving for too long
		if (took_in || took_out)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_epoch != hold_seen) begin
			hold_seen = hold_epoch;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial begin
		in_t         it;
		logic [31:0] val;
		int          mode;
		arst_n = 1'b0;

		// predictor reset state
		reg_shadow[REG_HYST_UP]        = '0;
		reg_shadow[REG_HYST_DOWN]      = '0;
		reg_shadow[REG_OFFSET_HIGH]    = '0;
		reg_shadow[REG_OFFSET_LOW]     = '0;
		reg_shadow[REG_SLOPE_HIGH]     = 32'd65536;
		reg_shadow[REG_SLOPE_LOW]      = 32'd65536;
		reg_shadow[REG_DAC_LIMIT]      = 32'h0000_FFFF;
		reg_shadow[REG_SETPOINT_LIMIT] = 32'hFFFF_FFFF;
		sp_model    = '0;
		range_model = 1'b1;
		err_model   = '0;

		// reset state and clamps under the reset calibration
		plan.push_back(gold_row(ACT_APPLY, 32'h0, 1'b1, 1'b1,
			out_t'({32'h0, 16'h0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0})));
		plan.push_back(gold_row(ACT_SET, 32'hFFFF_FFFF, 1'b1, 1'b1,
			out_t'({32'hFFFF_FFFF, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0})));
		plan.push_back(gold_row(ACT_APPLY, 32'h0, 1'b1, 1'b0,
			out_t'({32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'd1})));
		plan.push_back(gold_row(ACT_UP, 32'h1, 1'b1, 1'b1,
			out_t'({32'hFFFF_FFFE, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_DOWN, 32'hFFFF_FFFF, 1'b1, 1'b1,
			out_t'({32'h0, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_DOWN, 32'h0, 1'b0, 1'b0,
			out_t'({32'h0, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_UP, 32'h1234, 1'b1, 1'b1,
			out_t'({32'h1234, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_APPLY, 32'hFFFF_FFFF, 1'b0, 1'b1,
			out_t'({32'h1234, 16'h1234, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_SET, 32'hFFFF, 1'b1, 1'b1,
			out_t'({32'hFFFF, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_APPLY, 32'h0, 1'b1, 1'b1,
			out_t'({32'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_SET, 32'h1_0000, 1'b1, 1'b1,
			out_t'({32'h1_0000, 16'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1})));
		plan.push_back(gold_row(ACT_APPLY, 32'h0, 1'b1, 1'b1,
			out_t'({32'h1_0000, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1, 16'd2})));
		// hysteresis band with a negative low-range offset
		plan.push_back(cfg_row(REG_HYST_UP, 32'd1000));
		plan.push_back(cfg_row(REG_HYST_DOWN, 32'd500));
		plan.push_back(cfg_row(REG_OFFSET_LOW, 32'hFFFF_FF9C));
		plan.push_back(cfg_row(REG_SLOPE_LOW, 32'd32768));
		plan.push_back(item_row(ACT_SET, 32'd400, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_SET, 32'd700, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_SET, 32'd50, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b1, 1'b0));
		plan.push_back(item_row(ACT_SET, 32'd2000, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b1, 1'b1));
		// zero slope in either range, most negative high offset
		plan.push_back(cfg_row(REG_SLOPE_HIGH, 32'd0));
		plan.push_back(cfg_row(REG_OFFSET_HIGH, 32'h8000_0000));
		plan.push_back(item_row(ACT_SET, 32'hFFFF_FFFF, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b1, 1'b1));
		plan.push_back(cfg_row(REG_SLOPE_LOW, 32'd0));
		plan.push_back(item_row(ACT_SET, 32'd200, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b1, 1'b1));
		// zero dac limit, zero setpoint limit wrapping the clamp
		plan.push_back(cfg_row(REG_DAC_LIMIT, 32'd0));
		plan.push_back(cfg_row(REG_SETPOINT_LIMIT, 32'd0));
		plan.push_back(cfg_row(REG_OFFSET_HIGH, 32'h7FFF_FFFF));
		plan.push_back(item_row(ACT_UP, 32'd5, 1'b1, 1'b1));
		plan.push_back(item_row(ACT_APPLY, 32'd0, 1'b0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].idx, plan[i].wdata);
			end else begin
				offer(plan[i].item, plan[i].typed, plan[i].golden);
			end
		end

		// random calibration phases: all low extremes, all high, then mixed
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			for (int r = REG_HYST_UP; r <= REG_SETPOINT_LIMIT; r++) begin
				mode = (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 5);
				case (r)
				REG_HYST_UP, REG_HYST_DOWN:
					val = (mode == 0) ? 32'h0 : (mode == 1) ? 32'hFFFF_FFFF :
						(mode == 2) ? $urandom() : $urandom_range(0, 1 << 20);
				REG_OFFSET_HIGH, REG_OFFSET_LOW:
					val = (mode == 0) ? 32'h8000_0000 : (mode == 1) ? 32'h7FFF_FFFF :
						(mode == 2) ? $urandom() : $urandom_range(0, 4096) - 32'd2048;
				REG_SLOPE_HIGH, REG_SLOPE_LOW:
					val = (mode == 0) ? 32'h1 : (mode == 1) ? 32'hFFFF_FFFF :
						(mode == 2) ? $urandom() : $urandom_range(1 << 12, 1 << 18);
				REG_DAC_LIMIT:
					val = (mode == 0) ? 32'h0 : (mode == 1) ? 32'hFFFF :
						(mode == 2) ? $urandom() : $urandom_range(0, 65535);
				default:
					val = (mode == 0) ? 32'h1 : (mode == 1) ? 32'hFFFF_FFFF :
						(mode == 2) ? $urandom() : $urandom_range(1 << 16, 1 << 21);
				endcase
				write_reg(r[IDX_W-1:0], val);
			end
			calm = (ph == 2);
			if (ph == 3)
				hold_epoch++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				it.action = 2'($urandom_range(0, 3));
				case ($urandom_range(0, 9))
				0: it.amount = $urandom();
				1: it.amount = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
				default: it.amount = (it.action == ACT_SET) ? $urandom_range(0, 1 << 20) :
					$urandom_range(0, 1 << 15);
				endcase
				// autoranging mostly allowed so the hysteresis gets exercised
				it.autorange_ok = ($urandom_range(0, 9) != 0);
				it.mode_was_cv  = 1'($urandom_range(0, 1));
				offer(it, 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain();
		repeat (30) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		$display("run covered %0d item beats, %0d applies (%0d low range, %0d overloads)",
			n_sent, n_apply, n_low, n_ovl);
		$display("over %0d calibration phases with idling and one long output hold-off",
			RAND_PHASES + 1);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hdl/cvdr_pkg.sv
hdl/cvdr_frac_div.sv
hdl/cv_setpoint_dac_ranger_unit.sv
tb/sv/testbench.sv
